/* rtl/mip_pkg.sv */
// ----------------------------------------------------------------------------
// Modular inverse package
// Shared constants, control word layout and flag bundle for the microcoded
// modular inverse engine.
// ----------------------------------------------------------------------------
package mip_pkg;

	localparam int unsigned W = 30;
	localparam logic [W-1:0] PRIME = 30'd998244353;

	localparam int unsigned ADDR_W = 3;
	typedef logic [ADDR_W-1:0] addr_t;

	// Microprogram layout.
	localparam addr_t A_DISPATCH = 3'd0;
	localparam addr_t A_HALVE_U = 3'd1;
	localparam addr_t A_HALVE_V = 3'd2;
	localparam addr_t A_SUB_UV = 3'd3;
	localparam addr_t A_SUB_VU = 3'd4;
	localparam addr_t A_OUT_X1 = 3'd5;
	localparam addr_t A_OUT_X2 = 3'd6;
	localparam addr_t A_OUT_ZERO = 3'd7;

	typedef enum logic [2:0] {
		OP_NOP = 3'd0,
		OP_HALVE_U = 3'd1,
		OP_HALVE_V = 3'd2,
		OP_SUB_UV = 3'd3,
		OP_SUB_VU = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		JMP_NEXT = 2'd0,
		JMP_ALWAYS = 2'd1,
		JMP_DISPATCH = 2'd2,
		JMP_STOP = 2'd3
	} jmp_t;

	typedef enum logic [1:0] {
		OUT_NONE = 2'd0,
		OUT_X1 = 2'd1,
		OUT_X2 = 2'd2,
		OUT_ZERO = 2'd3
	} out_t;

	typedef struct packed {
		op_t op;
		jmp_t jmp;
		out_t outsel;
		addr_t target;
	} ctrl_t;

	typedef struct packed {
		logic u_zero;
		logic u_one;
		logic v_one;
		logic u_even;
		logic v_even;
		logic u_ge_v;
	} flags_t;

endpackage

/* rtl/mip_ucode_rom.sv */
// ----------------------------------------------------------------------------
// Modular inverse microcode table
// Read-only control store of the binary extended Euclid program.
// ----------------------------------------------------------------------------
module mip_ucode_rom
	import mip_pkg::*;
(
	input addr_t pc,
	output ctrl_t ctrl
);

	always_comb begin
		case (pc)
			A_DISPATCH: ctrl = '{op: OP_NOP, jmp: JMP_DISPATCH, outsel: OUT_NONE,
				target: A_DISPATCH};
			A_HALVE_U: ctrl = '{op: OP_HALVE_U, jmp: JMP_ALWAYS, outsel: OUT_NONE,
				target: A_DISPATCH};
			A_HALVE_V: ctrl = '{op: OP_HALVE_V, jmp: JMP_ALWAYS, outsel: OUT_NONE,
				target: A_DISPATCH};
			A_SUB_UV: ctrl = '{op: OP_SUB_UV, jmp: JMP_ALWAYS, outsel: OUT_NONE,
				target: A_DISPATCH};
			A_SUB_VU: ctrl = '{op: OP_SUB_VU, jmp: JMP_ALWAYS, outsel: OUT_NONE,
				target: A_DISPATCH};
			A_OUT_X1: ctrl = '{op: OP_NOP, jmp: JMP_STOP, outsel: OUT_X1,
				target: A_DISPATCH};
			A_OUT_X2: ctrl = '{op: OP_NOP, jmp: JMP_STOP, outsel: OUT_X2,
				target: A_DISPATCH};
			A_OUT_ZERO: ctrl = '{op: OP_NOP, jmp: JMP_STOP, outsel: OUT_ZERO,
				target: A_DISPATCH};
			default: ctrl = '{op: OP_NOP, jmp: JMP_STOP, outsel: OUT_ZERO,
				target: A_DISPATCH};
		endcase
	end

endmodule

/* rtl/mip_datapath.sv */
// ----------------------------------------------------------------------------
// Modular inverse datapath
// Holds u, v and their coefficients x1, x2, with one shared modular halver
// and one shared modular subtractor, and the result register.
// ----------------------------------------------------------------------------
module mip_datapath
	import mip_pkg::*;
(
	input logic clk,
	input logic load,
	input logic [W-1:0] value,
	input logic step_en,
	input ctrl_t ctrl,
	output flags_t flags,
	output logic [W-1:0] inverse,
	output logic not_invertible
);

	logic [W-1:0] u_q, v_q, x1_q, x2_q;
	logic [W-1:0] inverse_q;
	logic not_inv_q;

	logic [W-1:0] value_red;
	logic [W-1:0] half_in, half_out;
	logic [W:0] half_sum;
	logic [W-1:0] sub_ra, sub_rb, sub_r;
	logic [W-1:0] sub_xa, sub_xb, sub_x;
	logic [W:0] x_diff;
	logic swap;

	// One subtraction of the prime brings any 30-bit operand below the prime.
	assign value_red = (value >= PRIME) ? value - PRIME : value;

	// Halving modulo an odd prime: an odd coefficient gets the prime added first.
	assign half_in = (ctrl.op == OP_HALVE_U) ? x1_q : x2_q;
	assign half_sum = half_in[0] ? ({1'b0, half_in} + {1'b0, PRIME}) : {1'b0, half_in};
	assign half_out = half_sum[W:1];

	assign swap = (ctrl.op == OP_SUB_VU);
	assign sub_ra = swap ? v_q : u_q;
	assign sub_rb = swap ? u_q : v_q;
	assign sub_r = sub_ra - sub_rb;
	assign sub_xa = swap ? x2_q : x1_q;
	assign sub_xb = swap ? x1_q : x2_q;
	assign x_diff = {1'b0, sub_xa} - {1'b0, sub_xb};
	assign sub_x = x_diff[W] ? x_diff[W-1:0] + PRIME : x_diff[W-1:0];

	assign flags.u_zero = (u_q == '0);
	assign flags.u_one = (u_q == W'(1));
	assign flags.v_one = (v_q == W'(1));
	assign flags.u_even = ~u_q[0];
	assign flags.v_even = ~v_q[0];
	assign flags.u_ge_v = (u_q >= v_q);

	always_ff @(posedge clk) begin
		if (load) begin
			u_q <= value_red;
			v_q <= PRIME;
			x1_q <= W'(1);
			x2_q <= '0;
		end else if (step_en) begin
			case (ctrl.op)
				OP_HALVE_U: begin
					u_q <= u_q >> 1;
					x1_q <= half_out;
				end
				OP_HALVE_V: begin
					v_q <= v_q >> 1;
					x2_q <= half_out;
				end
				OP_SUB_UV: begin
					u_q <= sub_r;
					x1_q <= sub_x;
				end
				OP_SUB_VU: begin
					v_q <= sub_r;
					x2_q <= sub_x;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			case (ctrl.outsel)
				OUT_X1: begin
					inverse_q <= x1_q;
					not_inv_q <= 1'b0;
				end
				OUT_X2: begin
					inverse_q <= x2_q;
					not_inv_q <= 1'b0;
				end
				OUT_ZERO: begin
					inverse_q <= '0;
					not_inv_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	assign inverse = inverse_q;
	assign not_invertible = not_inv_q;

endmodule

/* rtl/mip_sequencer.sv */
// ----------------------------------------------------------------------------
// Modular inverse sequencer
// Step counter of the microprogram with plain, unconditional and multiway
// jumps, plus the busy flag and the done strobe.
// ----------------------------------------------------------------------------
module mip_sequencer
	import mip_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input ctrl_t ctrl,
	input flags_t flags,
	output addr_t pc,
	output logic busy,
	output logic done
);

	addr_t pc_q, pc_next, dispatch_addr;
	logic busy_q, done_q;

	// Priority matters: a finished u or v ends the program before any reduction.
	always_comb begin
		if (flags.u_zero) begin
			dispatch_addr = A_OUT_ZERO;
		end else if (flags.u_one) begin
			dispatch_addr = A_OUT_X1;
		end else if (flags.v_one) begin
			dispatch_addr = A_OUT_X2;
		end else if (flags.u_even) begin
			dispatch_addr = A_HALVE_U;
		end else if (flags.v_even) begin
			dispatch_addr = A_HALVE_V;
		end else if (flags.u_ge_v) begin
			dispatch_addr = A_SUB_UV;
		end else begin
			dispatch_addr = A_SUB_VU;
		end
	end

	always_comb begin
		case (ctrl.jmp)
			JMP_NEXT: pc_next = pc_q + addr_t'(1);
			JMP_ALWAYS: pc_next = ctrl.target;
			JMP_DISPATCH: pc_next = dispatch_addr;
			JMP_STOP: pc_next = A_DISPATCH;
			default: pc_next = A_DISPATCH;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= A_DISPATCH;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				pc_q <= A_DISPATCH;
				if (start) begin
					busy_q <= 1'b1;
				end
			end else begin
				pc_q <= pc_next;
				if (ctrl.jmp == JMP_STOP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign pc = pc_q;
	assign busy = busy_q;
	assign done = done_q;

endmodule

/* rtl/modular_inverse_prime_core.sv */
// ----------------------------------------------------------------------------
// Modular inverse modulo 998244353
// Returns the multiplicative inverse of a 30-bit operand modulo the prime.
// ----------------------------------------------------------------------------
// Usage:
// A request is taken at a rising edge where start is high and busy is low;
// value is sampled at that edge and reduced modulo the prime. busy stays high
// while the request is worked on. The result appears on inverse and
// not_invertible, marked by done, which is high for exactly one cycle; the receiver cannot
// hold it off, so it must capture it in that cycle.
// An operand that is a multiple of the prime returns inverse 0 with
// not_invertible set. Otherwise a binary extended Euclid microprogram runs:
// every step is a dispatch on the flags of u and v, then one halving or one
// modular subtraction, until a dispatch selects an output step.
// A new request can be taken in the cycle done is high. One request at a time.
// Reset clears the sequencer; the block is idle and ready right after it.
// ----------------------------------------------------------------------------
module modular_inverse_prime_core
	import mip_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [29:0] value,
	output logic done,
	output logic [29:0] inverse,
	output logic not_invertible
);

	addr_t pc;
	ctrl_t ctrl;
	flags_t flags;
	logic load;

	assign load = start & ~busy;

	mip_ucode_rom u_rom (
		.pc(pc),
		.ctrl(ctrl)
	);

	mip_sequencer u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.ctrl(ctrl),
		.flags(flags),
		.pc(pc),
		.busy(busy),
		.done(done)
	);

	mip_datapath u_dp (
		.clk(clk),
		.load(load),
		.value(value),
		.step_en(busy),
		.ctrl(ctrl),
		.flags(flags),
		.inverse(inverse),
		.not_invertible(not_invertible)
	);

endmodule

/* verif/mip_inverse_checker.sv */
// ----------------------------------------------------------------------------
// Modular inverse result checker
// Watches the request and result channels of the modular inverse core,
// predicts the inverse modulo the prime for every accepted request and
// compares each strobed result with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module mip_inverse_checker
	import mip_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic [29:0] value,
	input logic done,
	input logic [29:0] inverse,
	input logic not_invertible,
	output int pending,
	output int errors
);

	typedef struct packed {
		logic [29:0] inverse;
		logic not_invertible;
	} inv_result_t;

	inv_result_t inverse_q[$];
	int mismatch_count = 0;

	// Extended Euclid over the prime, with the coefficient kept reduced.
	function automatic inv_result_t modinv_predict(logic [29:0] operand);
		longint unsigned p;
		longint unsigned a;
		longint unsigned r0, r1, rn;
		longint unsigned t0, t1, tn;
		longint unsigned q;
		inv_result_t res;
		p = longint'(PRIME);
		a = longint'(operand);
		if (a >= p) begin
			a = a - p;
		end
		if (a == 0) begin
			res.inverse = '0;
			res.not_invertible = 1'b1;
			return res;
		end
		r0 = p;
		r1 = a;
		t0 = 0;
		t1 = 1;
		while (r1 != 0) begin
			q = r0 / r1;
			rn = r0 - q * r1;
			tn = (t0 + p - ((q % p) * t1) % p) % p;
			r0 = r1;
			r1 = rn;
			t0 = t1;
			t1 = tn;
		end
		res.inverse = 30'(t0 % p);
		res.not_invertible = 1'b0;
		return res;
	endfunction

	function automatic void note_mismatch(string what, inv_result_t want, inv_result_t got);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%0t: %s: expected inverse=%0d not_invertible=%0b,",
				$realtime, what, want.inverse, want.not_invertible,
				" got inverse=%0d not_invertible=%0b", got.inverse,
				got.not_invertible);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		inv_result_t want;
		inv_result_t got;
		if (!arst_n) begin
			pending <= 0;
		end else begin
			if (done) begin
				got.inverse = inverse;
				got.not_invertible = not_invertible;
				if (inverse_q.size() == 0) begin
					want = '0;
					note_mismatch("result with no request outstanding", want, got);
				end else begin
					want = inverse_q.pop_front();
					if (got.inverse !== want.inverse) begin
						note_mismatch("inverse mismatch", want, got);
					end else if (got.not_invertible !== want.not_invertible) begin
						note_mismatch("not_invertible mismatch", want, got);
					end
				end
			end
			if (start && !busy) begin
				inverse_q.push_back(modinv_predict(value));
			end
			pending <= inverse_q.size();
		end
	end

	assign errors = mismatch_count;

endmodule

/* verif/tb_modular_inverse_prime_core.sv */
// ----------------------------------------------------------------------------
// Modular inverse core testbench
// Sends directed corner operands and then random operands with bursts of
// idle cycles, and leaves the checking to the checker module beside the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_modular_inverse_prime_core;
	import mip_pkg::*;

	localparam int RANDOM_COUNT = 1800;
	localparam int CALM_TAIL = 300;
	localparam logic [29:0] ALL_ONES = 30'h3FFF_FFFF;

	logic clk;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [29:0] value = '0;
	logic busy;
	logic done;
	logic [29:0] inverse;
	logic not_invertible;
	int pending;
	int errors;

	modular_inverse_prime_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.value(value),
		.done(done),
		.inverse(inverse),
		.not_invertible(not_invertible)
	);

	mip_inverse_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.value(value),
		.done(done),
		.inverse(inverse),
		.not_invertible(not_invertible),
		.pending(pending),
		.errors(errors)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Holds the request up until the core takes it; start is left high.
	task automatic send_request(logic [29:0] operand);
		start <= 1'b1;
		value <= operand;
		do begin
			@(posedge clk);
		end while (busy);
	endtask

	task automatic pause_sender(int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// The pending count is registered and lags behind acceptance, hence the edge waited for before it is polled.
	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
	endtask

	function automatic logic [29:0] pick_operand();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel >= 8) begin
			return 30'($urandom());
		end
		case (sel)
			0: return '0;
			1: return PRIME;
			2: return 30'd1;
			3: return PRIME - 30'd1;
			4: return PRIME + 30'd1;
			5: return ALL_ONES;
			6: return 30'($urandom_range(int'(PRIME), int'(ALL_ONES)));
			default: return 30'($urandom_range(1, 64));
		endcase
	endfunction

	initial begin
		logic [29:0] corner_ops[$];
		bit calm;
		corner_ops = '{30'd0, 30'd1, 30'd2, 30'd3, PRIME - 30'd1, PRIME - 30'd2, PRIME,
			PRIME + 30'd1, PRIME + 30'd2, ALL_ONES, ALL_ONES - 30'd1, 30'd499122177,
			30'h2000_0000, 30'h1FFF_FFFF, 30'h2AAA_AAAA, 30'h1555_5555, 30'd65536,
			30'd12345678, 30'd998244351};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (corner_ops[i]) begin
			send_request(corner_ops[i]);
			if (i % 4 == 3) begin
				pause_sender($urandom_range(1, 12));
			end
		end

		// Let the core run dry once before the random part.
		drain_results();

		for (int i = 0; i < RANDOM_COUNT; i++) begin
			send_request(pick_operand());
			calm = (i >= RANDOM_COUNT - CALM_TAIL) || ((i / 150) % 3 == 2);
			if (i == RANDOM_COUNT / 2) begin
				drain_results();
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				pause_sender($urandom_range(1, 12));
			end
		end

		drain_results();
		repeat (260) @(posedge clk);

		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
